### rtl/mnrt_pkg.sv
`default_nettype none
package mnrt_pkg;
  localparam int NUM_CH = 16;
  localparam int NUM_NOTES = 128;
  localparam int ENTRY_W = 11;
  localparam int FALLBACK_CH = 8;

  localparam logic [1:0] CMD_EVENT = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;
  localparam logic [1:0] CMD_QUERY = 2'd3;

  localparam logic [1:0] MSG_OTHER = 2'd0;
  localparam logic [1:0] MSG_ON = 2'd1;
  localparam logic [1:0] MSG_OFF = 2'd2;

  localparam logic [2:0] RES_PASS = 3'd0;
  localparam logic [2:0] RES_ON = 3'd1;
  localparam logic [2:0] RES_OFF = 3'd2;
  localparam logic [2:0] RES_QUERY = 3'd3;
  localparam logic [2:0] RES_ACK = 3'd4;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [1:0]  msg_kind;
    logic [3:0]  in_channel;
    logic [6:0]  in_note;
    logic [6:0]  velocity;
    logic [31:0] sample_time;
    logic [23:0] raw_message;
    logic [3:0]  map_out_channel;
    logic [6:0]  map_out_note;
  } item_t;

  typedef struct packed {
    logic [2:0]  res_kind;
    logic [3:0]  out_channel;
    logic [6:0]  out_note;
    logic [6:0]  out_velocity;
    logic [31:0] out_time;
    logic [23:0] out_raw;
    logic        flag;
    logic        last;
  } result_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture input item
    logic rd_count;   // read count of selected entry
    logic use_fb;     // select fallback entry
    logic rd_pair;    // read pair at slot index
    logic next_slot;
    logic append;     // write pair and bump count
    logic set_active; // write active bit
    logic clr_step;   // clear one count entry
    logic clr_active; // clear one active bit (sweep after reset only)
    logic emit;       // load output register
    logic [2:0] emit_sel; // result kind to build
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] cmd;
    logic       note_msg;
    logic       note_on;
    logic       count_zero;
    logic       fb_ok;
    logic       slot_last;
    logic       clr_done;
    logic       out_busy;
  } stat_t;
endpackage
`default_nettype wire

### rtl/mnrt_if.sv
`default_nettype none
interface mnrt_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/mnrt_datapath.sv
`default_nettype none
module mnrt_datapath #(
  parameter int MAX_OUTS = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire mnrt_pkg::item_t  in_data,
  input  wire mnrt_pkg::cmd_t   ctl,
  output mnrt_pkg::stat_t       st,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output mnrt_pkg::result_t     out_data
);
  localparam int SLOT_W = (MAX_OUTS > 1) ? $clog2(MAX_OUTS) : 1;
  localparam int CNT_W = $clog2(MAX_OUTS + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam int PAIR_DEPTH = 2048 * (2 ** SLOT_W);

  mnrt_pkg::item_t item;
  logic [3:0] src_ch;
  logic [mnrt_pkg::ENTRY_W-1:0] own_e, src_e, clr_idx;
  logic [CNT_W-1:0] cnt, n;
  logic [SLOT_W-1:0] slot;
  logic shift;
  logic act_q;
  logic [10:0] pair_q;

  logic [CNT_W-1:0] count_mem [2048];
  logic [10:0] pair_mem [PAIR_DEPTH];
  logic active_mem [2048];

  logic [mnrt_pkg::ENTRY_W+SLOT_W-1:0] pair_addr;

  assign own_e = {item.in_channel, item.in_note};
  assign src_e = {src_ch, item.in_note};
  assign pair_addr = {src_e, slot};

  // counts: single port, read or write
  always_ff @(posedge clk) begin
    if (ctl.clr_step) count_mem[clr_idx] <= '0;
    else if (ctl.append && cnt < CNT_W'(MAX_OUTS)) count_mem[own_e] <= cnt + CNT_W'(1);
    else if (ctl.rd_count) cnt <= count_mem[src_e];
  end

  always_ff @(posedge clk) begin
    if (ctl.append && cnt < CNT_W'(MAX_OUTS))
      pair_mem[{own_e, cnt[SLOT_W-1:0]}] <= {item.map_out_channel, item.map_out_note};
    if (ctl.rd_pair) pair_q <= pair_mem[pair_addr];
  end

  // active bits are zeroed by the sweep that follows reset
  always_ff @(posedge clk) begin
    if (ctl.clr_active) active_mem[clr_idx] <= 1'b0;
    else if (ctl.set_active) active_mem[own_e] <= (item.msg_kind == mnrt_pkg::MSG_ON);
    act_q <= active_mem[own_e];
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      item <= in_data;
      src_ch <= in_data.in_channel;
      shift <= 1'b0;
      slot <= '0;
    end else if (ctl.use_fb) begin
      src_ch <= {1'b0, item.in_channel[2:0]};
      shift <= 1'b1;
    end else if (ctl.next_slot) begin
      slot <= slot + SLOT_W'(1);
    end
    if (ctl.rd_count) n <= '0;
    else if (ctl.use_fb) n <= '0;
    else n <= (cnt > CNT_W'(MAX_OUTS)) ? CNT_W'(MAX_OUTS) : cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) clr_idx <= '0;
    else if (ctl.clr_step) clr_idx <= clr_idx + 1'b1;
  end

  assign st.cmd = item.cmd;
  assign st.note_msg = (item.msg_kind == mnrt_pkg::MSG_ON) ||
                       (item.msg_kind == mnrt_pkg::MSG_OFF);
  assign st.note_on = (item.msg_kind == mnrt_pkg::MSG_ON);
  assign st.count_zero = (cnt == '0);
  assign st.fb_ok = item.in_channel[3] && !shift;
  assign st.slot_last = (SUM_W'(slot) + SUM_W'(1)) >= {1'b0, n};
  assign st.clr_done = (clr_idx == '1);
  assign st.out_busy = out_valid && !out_ready;

  mnrt_pkg::result_t r;
  always_comb begin
    r = '0;
    r.res_kind = ctl.emit_sel;
    r.last = 1'b1;
    case (ctl.emit_sel)
      mnrt_pkg::RES_PASS: begin
        r.out_time = item.sample_time;
        r.out_raw = item.raw_message;
      end
      mnrt_pkg::RES_ON, mnrt_pkg::RES_OFF: begin
        r.out_channel = pair_q[10:7] + (shift ? 4'd8 : 4'd0);
        r.out_note = pair_q[6:0];
        r.out_velocity = item.velocity;
        r.out_time = item.sample_time;
        r.last = st.slot_last;
      end
      mnrt_pkg::RES_QUERY: begin
        r.out_channel = item.in_channel;
        r.out_note = item.in_note;
        r.flag = act_q;
      end
      mnrt_pkg::RES_ACK: r.flag = (item.cmd == mnrt_pkg::CMD_CLEAR) ||
                                  (cnt < CNT_W'(MAX_OUTS));
      default: r = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (ctl.emit) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (ctl.emit) out_data <= r;
  end
endmodule
`default_nettype wire

### rtl/mnrt_ctrl.sv
`default_nettype none
module mnrt_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire mnrt_pkg::stat_t st,
  output mnrt_pkg::cmd_t       ctl
);
  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_RDCNT = 4'd2;
  localparam logic [3:0] S_DECIDE = 4'd3;
  localparam logic [3:0] S_FBWAIT = 4'd4;
  localparam logic [3:0] S_RDPAIR = 4'd5;
  localparam logic [3:0] S_EMIT = 4'd6;
  localparam logic [3:0] S_SINGLE = 4'd7;
  localparam logic [3:0] S_NCNT = 4'd8;
  localparam logic [3:0] S_WRAP = 4'd9;

  logic [3:0] state, state_next;
  logic emit_note;

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) emit_note <= 1'b0;
    else if (state == S_IDLE) emit_note <= 1'b0;
    else if (state == S_NCNT) emit_note <= 1'b1;
  end

  always_comb begin
    state_next = state;
    ctl = '0;
    in_ready = 1'b0;
    case (state)
      S_CLEAR: begin
        ctl.clr_step = 1'b1;
        // a clear command keeps the active bits
        ctl.clr_active = !emit_note;
        if (st.clr_done) state_next = emit_note ? S_SINGLE : S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load = 1'b1;
          state_next = S_RDCNT;
        end
      end
      S_RDCNT: begin
        ctl.rd_count = 1'b1;
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        case (st.cmd)
          mnrt_pkg::CMD_APPEND: begin
            ctl.append = 1'b1;
            state_next = S_SINGLE;
          end
          mnrt_pkg::CMD_CLEAR: state_next = S_NCNT;
          mnrt_pkg::CMD_QUERY: state_next = S_SINGLE;
          default: begin
            if (!st.note_msg) state_next = S_SINGLE;
            else if (!st.count_zero) state_next = S_RDPAIR;
            else if (st.fb_ok) begin
              ctl.use_fb = 1'b1;
              state_next = S_FBWAIT;
            end else state_next = S_SINGLE;
          end
        endcase
      end
      S_FBWAIT: begin
        ctl.rd_count = 1'b1;
        state_next = S_WRAP;
      end
      S_WRAP: begin
        if (st.count_zero) state_next = S_SINGLE;
        else state_next = S_RDPAIR;
      end
      S_RDPAIR: begin
        ctl.rd_pair = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!st.out_busy) begin
          ctl.emit = 1'b1;
          ctl.emit_sel = st.note_on ? mnrt_pkg::RES_ON : mnrt_pkg::RES_OFF;
          if (st.slot_last) begin
            ctl.set_active = 1'b1;
            state_next = S_IDLE;
          end else begin
            ctl.next_slot = 1'b1;
            state_next = S_RDPAIR;
          end
        end
      end
      S_NCNT: state_next = S_CLEAR;
      S_SINGLE: begin
        if (!st.out_busy) begin
          ctl.emit = 1'b1;
          case (st.cmd)
            mnrt_pkg::CMD_APPEND, mnrt_pkg::CMD_CLEAR: ctl.emit_sel = mnrt_pkg::RES_ACK;
            mnrt_pkg::CMD_QUERY: ctl.emit_sel = mnrt_pkg::RES_QUERY;
            default: ctl.emit_sel = mnrt_pkg::RES_PASS;
          endcase
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

### rtl/midi_note_remap_table_top.sv
`default_nettype none
// channel  dir  payload
// in_ch    in   mnrt_pkg::item_t   (cmd, event, mapping fields)
// out_ch   out  mnrt_pkg::result_t (one or more results per transaction)
//
// A mapped event reads its count (the fallback entry's if needed), then
// reads and emits each output pair in turn. Other transactions give one
// result (an unmapped note first checks the fallback entry). The table
// memories have one port each, so outputs are read one after another.
// After reset a pass clears counts and active bits; a clear command
// sweeps the counts only. out_ch stalls hold the controller in place.
module midi_note_remap_table_top #(
  parameter int MAX_OUTS = 4
) (
  input wire logic clk,
  input wire logic rst,
  mnrt_if.sink     in_ch,
  mnrt_if.source   out_ch
);
  mnrt_pkg::cmd_t  ctl;
  mnrt_pkg::stat_t st;
  mnrt_pkg::result_t res;

  mnrt_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .st(st), .ctl(ctl)
  );

  mnrt_datapath #(.MAX_OUTS(MAX_OUTS)) u_dp (
    .clk(clk), .rst(rst), .in_data(in_ch.data), .ctl(ctl), .st(st),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(res)
  );
  assign out_ch.data = res;
endmodule
`default_nettype wire
